### hw/rtl/snc_pkg.sv
// Shared types and constants for the SPI-NOR command chunker.
package snc_pkg;

    // Shared adder width: 33-bit capacities plus a borrow bit.
    localparam int ALU_W      = 34;
    localparam int MAX_FRAMES = 34;  // at most this many frames emitted per start transaction
    localparam int CNT_W      = $clog2(MAX_FRAMES);

    // Longest read or program request; the 13-bit length field is sized for it.
    localparam int MAX_REQUEST_BYTES = 4096;

    // Request kinds.
    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_PROGRAM = 2'd1;
    localparam logic [1:0] KIND_ERASE   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_FRAME = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_ALIGN = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ADDR_BYTES = 3'd0;
    localparam logic [2:0] CFG_CAPACITY   = 3'd1;
    localparam logic [2:0] CFG_PAGE_LOG2  = 3'd2;
    localparam logic [2:0] CFG_ERASE_LOG2 = 3'd3;
    localparam logic [2:0] CFG_READ_OP    = 3'd4;
    localparam logic [2:0] CFG_PROG_OP    = 3'd5;
    localparam logic [2:0] CFG_ERASE_OP   = 3'd6;

    // Register reset values.
    localparam logic [2:0]  RST_ADDR_BYTES = 3'd3;
    localparam logic [32:0] RST_CAPACITY   = 33'd33554432;
    localparam logic [4:0]  RST_PAGE_LOG2  = 5'd8;
    localparam logic [4:0]  RST_ERASE_LOG2 = 5'd16;
    localparam logic [7:0]  RST_READ_OP    = 8'h03;
    localparam logic [7:0]  RST_PROG_OP    = 8'h02;
    localparam logic [7:0]  RST_ERASE_OP   = 8'hd8;

    typedef struct packed {
        logic [2:0]  addr_bytes;
        logic [32:0] capacity;
        logic [4:0]  page_log2;
        logic [4:0]  erase_log2;
        logic [7:0]  read_op;
        logic [7:0]  prog_op;
        logic [7:0]  erase_op;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  opcode;
        logic [31:0] frame_address;
        logic [7:0]  data_count;
        logic [11:0] buffer_offset;
        logic        needs_write_enable;
        logic        needs_ready_wait;
        logic        last;
    } t_res;

endpackage

### hw/rtl/snc_alu.sv
// Shared add/subtract unit with carry out (carry set = no borrow on subtract).
module snc_alu
    import snc_pkg::*;
(
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    input  logic             i_sub,
    output logic [ALU_W-1:0] o_sum,
    output logic             o_carry
);

    logic [ALU_W-1:0] b_eff;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, i_sub};

endmodule

### hw/rtl/snc_seq.sv
// Request sequencer: range checks and frame splitting around one shared adder.
module snc_seq
    import snc_pkg::*;
#(
    parameter int BUF_BYTES = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_start_address,
    input  logic [12:0] i_byte_length,
    input  t_cfg        i_cfg,
    output logic        o_busy,
    output logic        o_res_valid,
    output t_res        o_res
);

    localparam int CW = $clog2(BUF_BYTES);
    localparam logic [CW-1:0] MAXD_3 = CW'(BUF_BYTES - 4);
    localparam logic [CW-1:0] MAXD_4 = CW'(BUF_BYTES - 5);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROOM  = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_ERASE = 3'd3;
    localparam logic [2:0] S_FA    = 3'd4;
    localparam logic [2:0] S_FB    = 3'd5;

    logic [2:0]       r_state, n_state;
    logic             r_pending, n_pending;
    logic [1:0]       r_kind, n_kind;
    logic [31:0]      r_base, n_base;
    logic [12:0]      r_len, n_len;
    logic [12:0]      r_done, n_done;
    logic [CNT_W-1:0] r_count, n_count;
    logic [32:0]      r_cap, n_cap;
    logic [32:0]      r_room, n_room;
    logic             r_bad, n_bad;
    logic [31:0]      r_cur, n_cur;
    logic [12:0]      r_left, n_left;

    logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
    logic             alu_sub, alu_carry;

    logic             ab4, prog;
    logic [32:0]      limit;
    logic [CW-1:0]    maxd, cand, chunk;
    logic [32:0]      pmask, psize;
    logic [31:0]      emask;
    logic [12:0]      done_next;
    logic             frame_last;

    snc_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign ab4   = (i_cfg.addr_bytes >= 3'd4);
    assign limit = ab4 ? (33'd1 << 32) : (33'd1 << 24);
    assign maxd  = ab4 ? MAXD_4 : MAXD_3;
    assign prog  = (r_kind == KIND_PROGRAM);
    assign psize = 33'd1 << i_cfg.page_log2;
    assign pmask = psize - 33'd1;
    assign emask = 32'((33'd1 << i_cfg.erase_log2) - 33'd1);

    // Candidate chunk: remaining bytes capped by the FIFO room.
    assign cand = (r_left > 13'(maxd)) ? maxd : r_left[CW-1:0];
    // Program frames stop at the page boundary (alu_sum holds bytes left in page).
    assign chunk = (prog && (alu_sum[32:0] < 33'(cand))) ? alu_sum[CW-1:0] : cand;
    assign done_next  = r_done + 13'(chunk);
    assign frame_last = (done_next >= r_len);

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_kind    = r_kind;
        n_base    = r_base;
        n_len     = r_len;
        n_done    = r_done;
        n_count   = r_count;
        n_cap     = r_cap;
        n_room    = r_room;
        n_bad     = r_bad;
        n_cur     = r_cur;
        n_left    = r_left;
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_count = '0;
                    if (r_pending) begin
                        // continuation of a long request: input is ignored
                        n_state = S_FA;
                    end else begin
                        n_kind = i_kind;
                        n_base = i_start_address;
                        n_len  = i_byte_length;
                        n_cap  = (i_cfg.capacity < limit) ? i_cfg.capacity : limit;
                        case (i_kind)
                            KIND_READ, KIND_PROGRAM: n_state = S_ROOM;
                            KIND_ERASE:              n_state = S_ERASE;
                            default:                 n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_ROOM: begin
                alu_a   = ALU_W'(r_cap);
                alu_b   = ALU_W'(r_base);
                alu_sub = 1'b1;
                n_room  = alu_sum[32:0];
                n_bad   = !alu_carry;
                n_state = S_LEN;
            end
            S_LEN: begin
                alu_a   = ALU_W'(r_room);
                alu_b   = ALU_W'(r_len);
                alu_sub = 1'b1;
                n_state = S_IDLE;
                if (r_bad || !alu_carry || (32'(r_len) > MAX_REQUEST_BYTES)) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_RANGE;
                    o_res.last   = 1'b1;
                end else if (r_len == 13'd0) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_EMPTY;
                    o_res.last   = 1'b1;
                end else begin
                    n_pending = 1'b1;
                    n_done    = '0;
                    n_state   = S_FA;
                end
            end
            S_ERASE: begin
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                n_state     = S_IDLE;
                if ((r_base & emask) != 32'd0) begin
                    o_res.status = ST_ALIGN;
                end else if (!ab4 && (r_base[31:24] != 8'd0)) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_res.status             = ST_FRAME;
                    o_res.opcode             = i_cfg.erase_op;
                    o_res.frame_address      = r_base;
                    o_res.needs_write_enable = 1'b1;
                    o_res.needs_ready_wait   = 1'b1;
                end
            end
            S_FA: begin
                alu_a   = ALU_W'(r_base);
                alu_b   = ALU_W'(r_done);
                n_cur   = alu_sum[31:0];
                n_left  = r_len - r_done;
                n_state = S_FB;
            end
            S_FB: begin
                alu_a   = ALU_W'(psize);
                alu_b   = ALU_W'(33'(r_cur) & pmask);
                alu_sub = 1'b1;
                o_res_valid              = 1'b1;
                o_res.status             = ST_FRAME;
                o_res.opcode             = prog ? i_cfg.prog_op : i_cfg.read_op;
                o_res.frame_address      = r_cur;
                o_res.data_count         = 8'(chunk);
                o_res.buffer_offset      = r_done[11:0];
                o_res.needs_write_enable = prog;
                o_res.needs_ready_wait   = prog;
                o_res.last               = frame_last;
                n_done = done_next;
                if (frame_last) begin
                    n_pending = 1'b0;
                    n_state   = S_IDLE;
                end else if (r_count == CNT_W'(MAX_FRAMES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_count = r_count + 1'b1;
                    n_state = S_FA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= 1'b0;
            r_done    <= '0;
            r_count   <= '0;
            r_bad     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_done    <= n_done;
            r_count   <= n_count;
            r_bad     <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_base <= n_base;
        r_len  <= n_len;
        r_cap  <= n_cap;
        r_room <= n_room;
        r_cur  <= n_cur;
        r_left <= n_left;
    end

`ifndef SYNTHESIS
    a_res_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_state == S_LEN || r_state == S_ERASE || r_state == S_FB))
        else $error("result emitted outside an emitting state");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !r_pending)
        else $error("request still pending after its last result");

    a_pending_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_done < r_len))
        else $error("pending request with no bytes left");

    a_chunk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FB) |-> (chunk != '0))
        else $error("empty frame emitted");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_FRAMES))
        else $error("frame counter overran");
`endif

endmodule

### hw/rtl/spi_nor_command_chunker.sv
// Top level of the SPI-NOR command chunker: config registers, sequencer, result register.
//
//  Channel   Signals                                   Transaction when
//  -------   ---------------------------------------   ---------------------------
//  request   start, busy, i_kind, i_start_address,     start && !busy
//            i_byte_length
//  result    o_valid, o_status ... o_last              o_valid (one cycle, no stall)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid && o_cfg_ready
//            i_cfg_data
//
// Sequencing: an erase is answered from its one check state (S_ERASE); read/program run
// the room check, then the length check, then per frame an address add and then a
// page-room subtract, all through the one shared adder. At most 34 frames per start;
// busy stays high until they are out, and a new request is taken only when busy is low.
// Long requests keep the remainder pending; each later start emits the next frames.
// Each result shows on the output register in the cycle after it is formed.
// Reset is synchronous active low; config registers return to their defaults.
// The result side cannot stall; config writes are always ready.
module spi_nor_command_chunker
    import snc_pkg::*;
#(
    parameter int BUF_BYTES = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_start_address,
    input  logic [12:0] i_byte_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [7:0]  o_opcode,
    output logic [31:0] o_frame_address,
    output logic [7:0]  o_data_count,
    output logic [11:0] o_buffer_offset,
    output logic        o_needs_write_enable,
    output logic        o_needs_ready_wait,
    output logic        o_last
);

    t_cfg r_cfg;
    logic r_valid;
    t_res r_res;
    logic res_valid;
    t_res res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.addr_bytes <= RST_ADDR_BYTES;
            r_cfg.capacity   <= RST_CAPACITY;
            r_cfg.page_log2  <= RST_PAGE_LOG2;
            r_cfg.erase_log2 <= RST_ERASE_LOG2;
            r_cfg.read_op    <= RST_READ_OP;
            r_cfg.prog_op    <= RST_PROG_OP;
            r_cfg.erase_op   <= RST_ERASE_OP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ADDR_BYTES: r_cfg.addr_bytes <= i_cfg_data[2:0];
                CFG_CAPACITY:   r_cfg.capacity   <= i_cfg_data;
                CFG_PAGE_LOG2:  r_cfg.page_log2  <= i_cfg_data[4:0];
                CFG_ERASE_LOG2: r_cfg.erase_log2 <= i_cfg_data[4:0];
                CFG_READ_OP:    r_cfg.read_op    <= i_cfg_data[7:0];
                CFG_PROG_OP:    r_cfg.prog_op    <= i_cfg_data[7:0];
                CFG_ERASE_OP:   r_cfg.erase_op   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    snc_seq #(
        .BUF_BYTES (BUF_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_kind          (i_kind),
        .i_start_address (i_start_address),
        .i_byte_length   (i_byte_length),
        .i_cfg           (r_cfg),
        .o_busy          (busy),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Output register: strobe for one cycle per result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_valid              = r_valid;
    assign o_status             = r_res.status;
    assign o_opcode             = r_res.opcode;
    assign o_frame_address      = r_res.frame_address;
    assign o_data_count         = r_res.data_count;
    assign o_buffer_offset      = r_res.buffer_offset;
    assign o_needs_write_enable = r_res.needs_write_enable;
    assign o_needs_ready_wait   = r_res.needs_ready_wait;
    assign o_last               = r_res.last;

endmodule

### tb/snc_frame_checker.sv
// Checker for the SPI-NOR command chunker: predicts the frames of each request and compares results.
`timescale 1ns / 1ps
module snc_frame_checker
    import snc_pkg::*;
#(
    parameter int BUF_BYTES = 256
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_start_address,
    input  logic [12:0] i_byte_length,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic [7:0]  o_opcode,
    input  logic [31:0] o_frame_address,
    input  logic [7:0]  o_data_count,
    input  logic [11:0] o_buffer_offset,
    input  logic        o_needs_write_enable,
    input  logic        o_needs_ready_wait,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_outstanding
);

    t_cfg        regs;
    t_res        frame_q[$];
    logic        owed;       // part of a long request still to be framed
    logic [1:0]  job_kind;
    logic [31:0] job_base;
    logic [12:0] job_len;
    logic [12:0] job_done;
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
        fails++;
    endtask

    function automatic int unsigned addr_width_bytes();
        if (regs.addr_bytes < 3'd3) return 3;
        if (regs.addr_bytes > 3'd4) return 4;
        return regs.addr_bytes;
    endfunction

    task automatic queue_status(logic [1:0] code);
        t_res r;
        r        = '0;
        r.status = code;
        r.last   = 1'b1;
        frame_q.push_back(r);
    endtask

    // At most MAX_FRAMES frames per transaction; registers are read as they are now.
    task automatic cut_frames();
        int              n;
        bit              prog;
        longint unsigned ceiling, page, cur, chunk, room_in_page;
        t_res            r;
        n       = 0;
        prog    = (job_kind == KIND_PROGRAM);
        ceiling = BUF_BYTES - 1 - addr_width_bytes();
        page    = 64'd1 << regs.page_log2;
        while (n < MAX_FRAMES && job_done < job_len) begin
            cur   = 64'(job_base) + 64'(job_done);
            chunk = 64'(job_len) - 64'(job_done);
            if (chunk > ceiling) chunk = ceiling;
            if (prog) begin
                room_in_page = page - (cur & (page - 64'd1));
                if (chunk > room_in_page) chunk = room_in_page;
            end
            job_done                = job_done + chunk[12:0];
            r                       = '0;
            r.status                = ST_FRAME;
            r.opcode                = prog ? regs.prog_op : regs.read_op;
            r.frame_address         = cur[31:0];
            r.data_count            = chunk[7:0];
            r.buffer_offset         = 12'(cur - 64'(job_base));
            r.needs_write_enable    = prog;
            r.needs_ready_wait      = prog;
            r.last                  = (job_done >= job_len);
            frame_q.push_back(r);
            n++;
        end
        if (job_done >= job_len) owed = 1'b0;
    endtask

    task automatic predict_request(logic [1:0] kind, logic [31:0] addr, logic [12:0] len);
        longint unsigned span_limit, reach, grain;
        t_res            r;
        if (owed) begin
            cut_frames();
            return;
        end
        span_limit = 64'd1 << (8 * addr_width_bytes());
        case (kind)
            KIND_ERASE: begin
                grain = 64'd1 << regs.erase_log2;
                if ((64'(addr) & (grain - 64'd1)) != 0) begin
                    queue_status(ST_ALIGN);
                end else if (64'(addr) > span_limit - 64'd1) begin
                    queue_status(ST_RANGE);
                end else begin
                    r                    = '0;
                    r.status             = ST_FRAME;
                    r.opcode             = regs.erase_op;
                    r.frame_address      = addr;
                    r.needs_write_enable = 1'b1;
                    r.needs_ready_wait   = 1'b1;
                    r.last               = 1'b1;
                    frame_q.push_back(r);
                end
            end
            KIND_READ, KIND_PROGRAM: begin
                reach = (64'(regs.capacity) < span_limit) ? 64'(regs.capacity) : span_limit;
                if (int'(len) > MAX_REQUEST_BYTES || 64'(addr) > reach ||
                    64'(len) > reach - 64'(addr)) begin
                    queue_status(ST_RANGE);
                end else if (len == 13'd0) begin
                    queue_status(ST_EMPTY);
                end else begin
                    owed     = 1'b1;
                    job_kind = kind;
                    job_base = addr;
                    job_len  = len;
                    job_done = '0;
                    cut_frames();
                end
            end
            default: ;  // unknown kind is dropped
        endcase
    endtask

    task automatic apply_reg_write(logic [2:0] idx, logic [32:0] data);
        case (idx)
            CFG_ADDR_BYTES: regs.addr_bytes = data[2:0];
            CFG_CAPACITY:   regs.capacity   = data;
            CFG_PAGE_LOG2:  regs.page_log2  = data[4:0];
            CFG_ERASE_LOG2: regs.erase_log2 = data[4:0];
            CFG_READ_OP:    regs.read_op    = data[7:0];
            CFG_PROG_OP:    regs.prog_op    = data[7:0];
            CFG_ERASE_OP:   regs.erase_op   = data[7:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            regs = '{addr_bytes: RST_ADDR_BYTES, capacity: RST_CAPACITY,
                     page_log2: RST_PAGE_LOG2, erase_log2: RST_ERASE_LOG2,
                     read_op: RST_READ_OP, prog_op: RST_PROG_OP, erase_op: RST_ERASE_OP};
            owed     = 1'b0;
            job_kind = '0;
            job_base = '0;
            job_len  = '0;
            job_done = '0;
            frame_q.delete();
            o_outstanding <= 0;
        end else begin
            if (o_valid) begin
                got.status             = o_status;
                got.opcode             = o_opcode;
                got.frame_address      = o_frame_address;
                got.data_count         = o_data_count;
                got.buffer_offset      = o_buffer_offset;
                got.needs_write_enable = o_needs_write_enable;
                got.needs_ready_wait   = o_needs_ready_wait;
                got.last               = o_last;
                if (frame_q.size() == 0) begin
                    report_mismatch("unrequested result, status", got.status, 0);
                end else begin
                    want = frame_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.opcode != want.opcode)
                        report_mismatch("opcode", got.opcode, want.opcode);
                    if (got.frame_address != want.frame_address)
                        report_mismatch("frame_address", got.frame_address, want.frame_address);
                    if (got.data_count != want.data_count)
                        report_mismatch("data_count", got.data_count, want.data_count);
                    if (got.buffer_offset != want.buffer_offset)
                        report_mismatch("buffer_offset", got.buffer_offset, want.buffer_offset);
                    if (got.needs_write_enable != want.needs_write_enable)
                        report_mismatch("needs_write_enable", got.needs_write_enable,
                                        want.needs_write_enable);
                    if (got.needs_ready_wait != want.needs_ready_wait)
                        report_mismatch("needs_ready_wait", got.needs_ready_wait,
                                        want.needs_ready_wait);
                    if (got.last != want.last)
                        report_mismatch("last", got.last, want.last);
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_reg_write(i_cfg_index, i_cfg_data);
            if (start && !busy) predict_request(i_kind, i_start_address, i_byte_length);
            o_outstanding <= frame_q.size();
        end
    end

endmodule

### tb/tb_spi_nor_command_chunker.sv
// Testbench top for the SPI-NOR command chunker: request stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_spi_nor_command_chunker;
    import snc_pkg::*;

    localparam int BUF_BYTES = 256;

    // Kind 3 and register index 7 have no meaning in the block; they must be dropped.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] CFG_SPARE   = 3'd7;

    localparam int ITEM_TARGET  = 470;
    localparam int PHASES       = 15;
    localparam int PHASE_ITEMS  = 30;
    localparam int QUIET_PHASES = 2;    // closing phases run without sender gaps
    localparam int SETTLE       = 80;   // margin past the longest busy stretch plus output stage

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic [1:0]  i_kind          = '0;
    logic [31:0] i_start_address = '0;
    logic [12:0] i_byte_length   = '0;
    logic        i_cfg_valid     = 1'b0;
    logic [2:0]  i_cfg_index     = '0;
    logic [32:0] i_cfg_data      = '0;

    logic        busy;
    logic        o_cfg_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_opcode;
    logic [31:0] o_frame_address;
    logic [7:0]  o_data_count;
    logic [11:0] o_buffer_offset;
    logic        o_needs_write_enable;
    logic        o_needs_ready_wait;
    logic        o_last;

    int fail_count;
    int outstanding;

    // Run statistics for the closing summary.
    int n_items    = 0;
    int n_unused   = 0;
    int n_results  = 0;
    int n_reg_wr   = 0;
    int n_settings = 0;

    // Sender behavior: random gaps and full drains, switched off near the end.
    bit gaps_on = 1'b1;

    // Stimulus-side view of the registers, only used to aim addresses and lengths.
    int unsigned sh_ab    = 3;
    logic [32:0] sh_cap   = RST_CAPACITY;
    int unsigned sh_page  = RST_PAGE_LOG2;
    int unsigned sh_erase = RST_ERASE_LOG2;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    spi_nor_command_chunker #(
        .BUF_BYTES (BUF_BYTES)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_kind               (i_kind),
        .i_start_address      (i_start_address),
        .i_byte_length        (i_byte_length),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .o_status             (o_status),
        .o_opcode             (o_opcode),
        .o_frame_address      (o_frame_address),
        .o_data_count         (o_data_count),
        .o_buffer_offset      (o_buffer_offset),
        .o_needs_write_enable (o_needs_write_enable),
        .o_needs_ready_wait   (o_needs_ready_wait),
        .o_last               (o_last)
    );

    snc_frame_checker #(
        .BUF_BYTES (BUF_BYTES)
    ) frame_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_kind               (i_kind),
        .i_start_address      (i_start_address),
        .i_byte_length        (i_byte_length),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .o_status             (o_status),
        .o_opcode             (o_opcode),
        .o_frame_address      (o_frame_address),
        .o_data_count         (o_data_count),
        .o_buffer_offset      (o_buffer_offset),
        .o_needs_write_enable (o_needs_write_enable),
        .o_needs_ready_wait   (o_needs_ready_wait),
        .o_last               (o_last),
        .o_fail_count         (fail_count),
        .o_outstanding        (outstanding)
    );

    always @(posedge i_clk)
        if (i_rst_n && o_valid) n_results++;

    // Accessible capacity as the stimulus sees it: physical size capped by address width.
    function automatic longint unsigned reach();
        longint unsigned span_limit;
        span_limit = 64'd1 << (8 * sh_ab);
        return (64'(sh_cap) < span_limit) ? 64'(sh_cap) : span_limit;
    endfunction

    // Optionally fill the unused upper bits of a register write with noise.
    function automatic logic [32:0] pad_bits(logic [32:0] v, int w, bit junk);
        logic [32:0] j;
        j = 33'({$urandom, $urandom});
        if (!junk || w >= 33) return v;
        return (j & ~((33'd1 << w) - 33'd1)) | v;
    endfunction

    // Wait until the block is idle and every predicted result has come back.
    task automatic drain(int settle);
        int guard;
        guard = 0;
        @(posedge i_clk);
        while ((outstanding != 0 || busy) && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // One register transaction; valid is left high so writes can run back to back.
    task automatic write_reg(logic [2:0] idx, logic [32:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_reg_wr++;
        case (idx)
            CFG_ADDR_BYTES: sh_ab    = (data[2:0] < 3'd3) ? 3 : (data[2:0] > 3'd4) ? 4 : data[2:0];
            CFG_CAPACITY:   sh_cap   = data;
            CFG_PAGE_LOG2:  sh_page  = data[4:0];
            CFG_ERASE_LOG2: sh_erase = data[4:0];
            default: ;
        endcase
    endtask

    // Write a register setting: all registers, or a random subset of them.
    task automatic set_regs(bit all_regs, bit junk, logic [2:0] ab, logic [32:0] cap,
                            logic [4:0] page, logic [4:0] erase,
                            logic [7:0] rop, logic [7:0] pop, logic [7:0] eop);
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_ADDR_BYTES, pad_bits(33'(ab), 3, junk));
        if (all_regs || $urandom_range(0, 1)) write_reg(CFG_CAPACITY, cap);
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_PAGE_LOG2, pad_bits(33'(page), 5, junk));
        if (all_regs || $urandom_range(0, 1))
            write_reg(CFG_ERASE_LOG2, pad_bits(33'(erase), 5, junk));
        if (all_regs || $urandom_range(0, 1)) write_reg(CFG_READ_OP, pad_bits(33'(rop), 8, junk));
        if (all_regs || $urandom_range(0, 1)) write_reg(CFG_PROG_OP, pad_bits(33'(pop), 8, junk));
        if (all_regs || $urandom_range(0, 1)) write_reg(CFG_ERASE_OP, pad_bits(33'(eop), 8, junk));
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // One request transaction. start stays high into the next request unless a gap
    // or a full drain follows, so there is never more than one update of start per edge.
    task automatic send_item(logic [1:0] kind, logic [31:0] addr, logic [12:0] len);
        start           <= 1'b1;
        i_kind          <= kind;
        i_start_address <= addr;
        i_byte_length   <= len;
        do @(posedge i_clk); while (busy);
        if (kind == KIND_UNUSED) n_unused++;
        else n_items++;
        if (gaps_on && $urandom_range(0, 39) == 0) begin
            start <= 1'b0;
            drain(0);
        end else if (gaps_on && $urandom_range(0, 6) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Random request: mostly in-range reads and programs with random lengths and addresses, then
    // erases (aligned and not), out-of-range noise, zero lengths and unknown kinds.
    task automatic random_request();
        int              pick;
        logic [1:0]      kind;
        logic [31:0]     addr;
        int unsigned     len_i;
        longint unsigned room, span, grain_mask;
        pick = $urandom_range(0, 99);
        room = reach();
        if (pick < 70) begin
            kind = $urandom_range(0, 1) ? KIND_PROGRAM : KIND_READ;
            case ($urandom_range(0, 3))
                0:       len_i = MAX_REQUEST_BYTES;
                1:       len_i = $urandom_range(1, 8);
                default: len_i = $urandom_range(1, MAX_REQUEST_BYTES);
            endcase
            // tiny pages split into a frame per page: keep those requests short
            if (kind == KIND_PROGRAM && sh_page < 6 && len_i > 256) len_i = $urandom_range(1, 256);
            if (len_i > room) len_i = 32'(room);
            span = room - len_i;
            if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
            addr = ($urandom_range(0, 4) == 0) ? span[31:0] : $urandom_range(0, span[31:0]);
            send_item(kind, addr, 13'(len_i));
        end else if (pick < 80) begin
            addr = $urandom;
            if (sh_ab == 3 && $urandom_range(0, 1)) addr[31:24] = 8'h00;
            grain_mask = (64'd1 << sh_erase) - 64'd1;
            if ($urandom_range(0, 2) != 0) addr = addr & ~grain_mask[31:0];
            send_item(KIND_ERASE, addr, 13'($urandom_range(0, 8191)));
        end else if (pick < 88) begin
            kind = $urandom_range(0, 1) ? KIND_PROGRAM : KIND_READ;
            send_item(kind, $urandom, 13'($urandom_range(0, 8191)));
        end else if (pick < 94) begin
            kind = $urandom_range(0, 1) ? KIND_PROGRAM : KIND_READ;
            span = (room > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : room;
            send_item(kind, $urandom_range(0, span[31:0]), 13'd0);
        end else begin
            send_item(KIND_UNUSED, $urandom, 13'($urandom_range(0, 8191)));
        end
    endtask

    initial begin
        int          p;
        int          phase_end;
        logic [2:0]  ab;
        logic [32:0] cap;
        logic [4:0]  page;
        logic [4:0]  erase;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed part at the reset register values: 3 address bytes (16 MiB reach),
        // 256-byte pages, 64 KiB sectors.
        send_item(KIND_READ,    32'h0000_0000, 13'd0);      // empty request
        send_item(KIND_READ,    32'h0000_0000, 13'd4096);   // full-length read
        send_item(KIND_PROGRAM, 32'h0000_00FF, 13'd300);    // crosses a page boundary
        send_item(KIND_PROGRAM, 32'h0000_0001, 13'd4096);   // unaligned, close to 34 frames
        send_item(KIND_ERASE,   32'h0001_0000, 13'd0);      // aligned sector
        send_item(KIND_ERASE,   32'h0001_0001, 13'd0);      // misaligned sector
        send_item(KIND_ERASE,   32'h0100_0000, 13'd0);      // aligned but past 24 address bits
        send_item(KIND_ERASE,   32'hFFFF_0001, 13'h1FFF);   // alignment wins over range
        send_item(KIND_READ,    32'hFFFF_FFFF, 13'd0);      // bad range beats zero length
        send_item(KIND_READ,    32'h0000_0000, 13'd4097);   // one byte over the request cap
        send_item(KIND_PROGRAM, 32'h0000_0000, 13'h1FFF);   // largest length field
        send_item(KIND_UNUSED,  32'hFFFF_FFFF, 13'h1FFF);   // unknown kind, dropped
        send_item(KIND_READ,    32'h00FF_FFFF, 13'd1);      // last accessible byte
        send_item(KIND_READ,    32'h0100_0000, 13'd0);      // at the capacity, empty
        send_item(KIND_PROGRAM, 32'h0100_0000, 13'd1);      // one past the capacity

        // 4 address bytes, full 4 GiB reach, 16-byte pages, byte-sized sectors.
        start <= 1'b0;
        drain(SETTLE);
        set_regs(1'b1, 1'b0, 3'd4, 33'h1_0000_0000, 5'd4, 5'd0, 8'h13, 8'h12, 8'hdc);
        send_item(KIND_PROGRAM, 32'hFFFF_FDA5, 13'd600);    // more than 34 frames: split
        send_item(KIND_UNUSED,  32'h0000_0000, 13'd0);      // carries on the long request
        send_item(KIND_READ,    32'hFFFF_F000, 13'd4096);   // ends exactly at 4 GiB
        send_item(KIND_READ,    32'hFFFF_FFFF, 13'd1);
        send_item(KIND_READ,    32'hFFFF_FFFF, 13'd2);      // wraps past the top
        send_item(KIND_ERASE,   32'hFFFF_FFFF, 13'd0);      // top address, any alignment

        // Random phases. Each one drains the block, changes the registers, then
        // issues a batch of requests; the first few pin the register extremes.
        for (p = 0; p < PHASES; p++) begin
            start <= 1'b0;
            drain(SETTLE);
            gaps_on = (p < PHASES - QUIET_PHASES);
            case (p)
                0: set_regs(1'b1, 1'b0, 3'd4, 33'h1_0000_0000, 5'd16, 5'd24,
                            8'h13, 8'h12, 8'hdc);
                1: begin
                    write_reg(CFG_SPARE, 33'({$urandom, $urandom}));  // must be ignored
                    set_regs(1'b1, 1'b1, 3'd0, 33'd1, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00);
                end
                2: set_regs(1'b1, 1'b1, 3'd7, 33'h1_FFFF_FFFF, 5'd31, 5'd31,
                            8'hff, 8'hff, 8'hff);
                3: set_regs(1'b1, 1'b0, 3'd3, 33'd0, 5'd8, 5'd16,
                            RST_READ_OP, RST_PROG_OP, RST_ERASE_OP);
                default: begin
                    ab    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7)
                                                        : $urandom_range(3, 4);
                    case ($urandom_range(0, 3))
                        0:       cap = 33'({$urandom, $urandom});
                        1:       cap = 33'h1_0000_0000;
                        2:       cap = RST_CAPACITY;
                        default: cap = $urandom_range(1, 1 << 20);
                    endcase
                    page  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(6, 16);
                    erase = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 31)
                                                        : $urandom_range(0, 24);
                    set_regs(1'b0, 1'($urandom_range(0, 1)), ab, cap, page, erase,
                             8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
            phase_end = n_items + PHASE_ITEMS;
            while (n_items < phase_end) random_request();
        end

        start <= 1'b0;
        drain(SETTLE + 20);

        $display("covered %0d requests plus %0d of unknown kind, %0d register writes in %0d settings",
                 n_items, n_unused, n_reg_wr, n_settings);
        $display("checked %0d results, %0d predicted results never arrived", n_results, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("spi_nor_command_chunker: match");
        end else begin
            $display("spi_nor_command_chunker: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (about 500 requests, each with up to
    // its longest busy stretch, plus gaps, drains and register phases).
    initial begin
        #5_000_000;
        $display("spi_nor_command_chunker: mismatch");
        $finish;
    end

endmodule
